/* hdl/tpb_pkg.sv */
`timescale 1ns / 1ps
package tpb_pkg;

  typedef enum logic [2:0] {
    MODE_MIN_WHITE = 3'd0,
    MODE_MIN_BLACK = 3'd1,
    MODE_RGB       = 3'd2,
    MODE_CMYK      = 3'd3,
    MODE_YCBCR     = 3'd4,
    MODE_OTHER     = 3'd5,
    MODE_OTHER6    = 3'd6,
    MODE_OTHER7    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    DEPTH_8     = 2'd0,
    DEPTH_16    = 2'd1,
    DEPTH_FLOAT = 2'd2,
    DEPTH_NONE  = 2'd3
  } depth_e;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_DEPTH = 3'd1;
  localparam logic [2:0] REG_SPP   = 3'd2;
  localparam logic [2:0] REG_WLOW  = 3'd3;
  localparam logic [2:0] REG_WHIGH = 3'd4;

  typedef struct packed {
    logic [31:0] sample_a;
    logic [31:0] sample_b;
    logic [31:0] sample_c;
    logic [31:0] sample_d;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pix_out_t;

  typedef struct packed {
    mode_e       mode;
    depth_e      depth;
    logic [2:0]  spp;
    logic [15:0] lo;
    logic [15:0] span;
  } cfg_t;

  // Per-lane work carried from stage 1 to stage 2.
  typedef struct packed {
    logic [1:0]  sel;     // 0 direct, 1 product, 2 zero, 3 full
    logic [7:0]  direct;
    logic [32:0] prod;
    logic [5:0]  sh;
  } lane_t;

  localparam logic [1:0] SEL_DIRECT = 2'd0;
  localparam logic [1:0] SEL_PROD   = 2'd1;
  localparam logic [1:0] SEL_ZERO   = 2'd2;
  localparam logic [1:0] SEL_FULL   = 2'd3;

endpackage

/* hdl/tpb_lane.sv */
`timescale 1ns / 1ps
// Stage-1 lane: maps one sample to a multiply job (window, float or CMYK), a direct value, or a zero/full clamp.
module tpb_lane (
  input  tpb_pkg::cfg_t  cfg_i,
  input  logic [31:0]    raw_i,
  input  logic           cmyk_i,
  input  logic [7:0]     k_i,
  output tpb_pkg::lane_t lane_o
);
  logic [15:0] v, lo, hi;
  logic [7:0]  ex;
  logic [22:0] man;

  always_comb begin
    v   = raw_i[15:0];
    lo  = cfg_i.lo;
    hi  = 16'(cfg_i.lo + cfg_i.span);
    ex  = raw_i[30:23];
    man = raw_i[22:0];
    lane_o.sel    = tpb_pkg::SEL_DIRECT;
    lane_o.direct = raw_i[7:0];
    lane_o.prod   = '0;
    lane_o.sh     = '0;
    case (cfg_i.depth)
      tpb_pkg::DEPTH_8: begin
        if (cmyk_i) begin
          // (255-p)(255-k)/255 via the divide stage
          lane_o.sel  = tpb_pkg::SEL_PROD;
          lane_o.prod = 33'({8'd0, 8'hFF - raw_i[7:0]} * {8'd0, 8'hFF - k_i});
        end
      end
      tpb_pkg::DEPTH_16: begin
        if (v <= lo) lane_o.sel = tpb_pkg::SEL_ZERO;
        else if (v >= hi) lane_o.sel = tpb_pkg::SEL_FULL;
        else begin
          lane_o.sel  = tpb_pkg::SEL_PROD;
          lane_o.prod = {1'b0, 32'(v - lo) * 32'd255};
        end
      end
      tpb_pkg::DEPTH_FLOAT: begin
        if (ex == 8'hFF) begin
          lane_o.sel = (man != '0 || raw_i[31]) ? tpb_pkg::SEL_ZERO : tpb_pkg::SEL_FULL;
        end else if (raw_i[31] || ex == 8'd0 || ex < 8'd118) begin
          lane_o.sel = tpb_pkg::SEL_ZERO;
        end else if (ex >= 8'd127) begin
          lane_o.sel = tpb_pkg::SEL_FULL;
        end else begin
          lane_o.sel  = tpb_pkg::SEL_PROD;
          lane_o.sh   = 6'(8'd150 - ex);
          lane_o.prod = {1'b0, 32'({1'b1, man}) * 32'd255};
        end
      end
      default: lane_o.sel = tpb_pkg::SEL_ZERO;
    endcase
  end
endmodule

/* hdl/tpb_finish.sv */
`timescale 1ns / 1ps
// Stage-2/3 lane: rounding shift for float, restoring divide for window and CMYK.
module tpb_finish (
  input  logic           clk_i,
  input  logic           en_i,
  input  tpb_pkg::cfg_t  cfg_i,
  input  tpb_pkg::lane_t lane_i,
  output logic [7:0]     val_o
);
  logic [1:0]  sel_q, sel_d;
  logic [7:0]  dir_q;
  logic [32:0] rem_q;
  logic [16:0] den_q;
  logic [3:0]  qhi_q;
  logic [7:0]  quo_q;
  logic [32:0] rnd;
  logic [7:0]  shv;
  logic [16:0] den_d;
  logic [32:0] rem_d;
  logic [3:0]  qhi_d;
  logic [32:0] rem_lo;
  logic [3:0]  qlo;
  logic        is_float_q;

  // Restoring divider over 8 quotient bits: quotient fits in 8 bits by range.
  // Upper four bits are found here, lower four in the next stage.
  always_comb begin
    rnd = lane_i.prod + (33'd1 << (lane_i.sh - 6'd1));
    shv = 8'(rnd >> lane_i.sh);
    sel_d = lane_i.sel;
    den_d = (cfg_i.depth == tpb_pkg::DEPTH_8) ? 17'd255 :
            ((cfg_i.span == '0) ? 17'd65535 : {1'b0, cfg_i.span});
    rem_d = lane_i.prod;
    qhi_d = '0;
    for (int i = 3; i >= 0; i--) begin
      if (rem_d >= (33'(den_d) << (i + 4))) begin
        rem_d    = rem_d - (33'(den_d) << (i + 4));
        qhi_d[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q      <= sel_d;
      dir_q      <= (cfg_i.depth == tpb_pkg::DEPTH_FLOAT) ? shv : lane_i.direct;
      is_float_q <= (cfg_i.depth == tpb_pkg::DEPTH_FLOAT);
      rem_q      <= rem_d;
      den_q      <= den_d;
      qhi_q      <= qhi_d;
    end
  end

  always_comb begin
    rem_lo = rem_q;
    qlo    = '0;
    for (int i = 3; i >= 0; i--) begin
      if (rem_lo >= (33'(den_q) << i)) begin
        rem_lo = rem_lo - (33'(den_q) << i);
        qlo[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (sel_q)
        tpb_pkg::SEL_DIRECT: quo_q <= dir_q;
        tpb_pkg::SEL_PROD:   quo_q <= is_float_q ? dir_q : {qhi_q, qlo};
        tpb_pkg::SEL_ZERO:   quo_q <= 8'd0;
        tpb_pkg::SEL_FULL:   quo_q <= 8'd255;
        default:             quo_q <= 8'd0;
      endcase
    end
  end

  assign val_o = quo_q;
endmodule

/* hdl/tiff_pixel_to_bgra.sv */
`timescale 1ns / 1ps
// Pixel format converter to 8-bit blue/green/red/alpha. One pixel word per
// clock while the output is not stalled; each word passes through the lane
// decode and multiply, the rounding shift and upper half of the divide, the
// lower half of the divide, and the channel select into the output register. The
// pipeline advances whenever the output register is empty or being taken, so a
// stalled output holds every stage and nothing is lost or repeated. Registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i and must only change while
// the pipeline is empty. 16-bit window division is done by a restoring
// divider split over stages 2 and 3, four quotient bits in each; CMYK uses
// the same divider with divisor 255.
module tiff_pixel_to_bgra (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tpb_pkg::pix_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tpb_pkg::pix_out_t  out_data_o
);
  tpb_pkg::mode_e  mode_q;
  tpb_pkg::depth_e depth_q;
  logic [2:0]  spp_q;
  logic [15:0] wlo_q, whi_q;
  tpb_pkg::cfg_t cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tpb_pkg::MODE_RGB;
      depth_q <= tpb_pkg::DEPTH_8;
      spp_q   <= 3'd3;
      wlo_q   <= 16'd0;
      whi_q   <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpb_pkg::REG_MODE:  mode_q  <= tpb_pkg::mode_e'(cfg_data_i[2:0]);
        tpb_pkg::REG_DEPTH: depth_q <= tpb_pkg::depth_e'(cfg_data_i[1:0]);
        tpb_pkg::REG_SPP:   spp_q   <= cfg_data_i[2:0];
        tpb_pkg::REG_WLOW:  wlo_q   <= cfg_data_i;
        tpb_pkg::REG_WHIGH: whi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective window and clamped sample count.
  logic [2:0] spp;
  logic [2:0] chans;
  logic       extra;
  logic       win;
  always_comb begin
    spp = (spp_q == 3'd0) ? 3'd1 : ((spp_q > 3'd4) ? 3'd4 : spp_q);
    case (mode_q)
      tpb_pkg::MODE_MIN_WHITE, tpb_pkg::MODE_MIN_BLACK: chans = 3'd1;
      tpb_pkg::MODE_RGB, tpb_pkg::MODE_YCBCR:           chans = 3'd3;
      tpb_pkg::MODE_CMYK:                               chans = 3'd4;
      default:                                          chans = spp;
    endcase
    extra = spp > chans;
    win   = whi_q > wlo_q;
    cfg.mode  = mode_q;
    cfg.depth = depth_q;
    cfg.spp   = spp;
    cfg.lo    = win ? wlo_q : 16'd0;
    cfg.span  = win ? 16'(whi_q - wlo_q) : 16'hFFFF;
  end

  // Pipeline control: all stages move together.
  logic adv;
  logic [3:0] v_q;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[2:0], in_valid_i};
  end
  assign out_valid_o = v_q[3];

  // Stage 1: lane decode, product registered.
  logic cmyk8;
  assign cmyk8 = (mode_q == tpb_pkg::MODE_CMYK);
  tpb_pkg::lane_t ln_a, ln_b, ln_c, ln_d;
  tpb_pkg::lane_t l1a_q, l1b_q, l1c_q, l1d_q;
  tpb_lane u_la (.cfg_i(cfg), .raw_i(in_data_i.sample_a), .cmyk_i(cmyk8),
                 .k_i(in_data_i.sample_d[7:0]), .lane_o(ln_a));
  tpb_lane u_lb (.cfg_i(cfg), .raw_i(in_data_i.sample_b), .cmyk_i(cmyk8),
                 .k_i(in_data_i.sample_d[7:0]), .lane_o(ln_b));
  tpb_lane u_lc (.cfg_i(cfg), .raw_i(in_data_i.sample_c), .cmyk_i(cmyk8),
                 .k_i(in_data_i.sample_d[7:0]), .lane_o(ln_c));
  tpb_lane u_ld (.cfg_i(cfg), .raw_i(in_data_i.sample_d), .cmyk_i(1'b0),
                 .k_i(8'd0), .lane_o(ln_d));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1a_q <= ln_a;
      l1b_q <= ln_b;
      l1c_q <= ln_c;
      l1d_q <= ln_d;
    end
  end

  // Stages 2 and 3: divide / round per lane.
  logic [7:0] fa, fb, fc, fd;
  tpb_finish u_fa (.clk_i(clk_i), .en_i(adv), .cfg_i(cfg), .lane_i(l1a_q), .val_o(fa));
  tpb_finish u_fb (.clk_i(clk_i), .en_i(adv), .cfg_i(cfg), .lane_i(l1b_q), .val_o(fb));
  tpb_finish u_fc (.clk_i(clk_i), .en_i(adv), .cfg_i(cfg), .lane_i(l1c_q), .val_o(fc));
  tpb_finish u_fd (.clk_i(clk_i), .en_i(adv), .cfg_i(cfg), .lane_i(l1d_q), .val_o(fd));

  // Stage 4: channel selection into the output register.
  tpb_pkg::pix_out_t res_d, res_q;
  always_comb begin
    res_d.alpha = 8'd255;
    res_d.blue  = fc;
    res_d.green = fb;
    res_d.red   = fa;
    if (depth_q == tpb_pkg::DEPTH_NONE) begin
      res_d = '0;
    end else if (depth_q == tpb_pkg::DEPTH_8) begin
      case (mode_q)
        tpb_pkg::MODE_RGB, tpb_pkg::MODE_YCBCR: begin
          if (extra) res_d.alpha = fd;
        end
        tpb_pkg::MODE_MIN_BLACK: begin
          res_d.blue = fa; res_d.green = fa; res_d.red = fa;
        end
        tpb_pkg::MODE_MIN_WHITE: begin
          res_d.blue = ~fa; res_d.green = ~fa; res_d.red = ~fa;
        end
        tpb_pkg::MODE_CMYK: ;
        default: begin
          res_d.blue  = fa;
          res_d.green = (spp > 3'd1) ? fb : fa;
          res_d.red   = (spp > 3'd2) ? fc : fa;
        end
      endcase
    end else if (mode_q == tpb_pkg::MODE_RGB) begin
      if (extra) res_d.alpha = fd;
    end else begin
      res_d.blue = fa; res_d.green = fa; res_d.red = fa;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end
  assign out_data_o = res_q;
endmodule
